>>> src/assert_macros.svh
// Assertion macros for the RTL that carries checks; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PDFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define PDFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pdfm_pkg.sv
// Shared types and constants for the PWM duty and frequency meter.
`default_nettype none
package pdfm_pkg;

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_INTERVAL  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_SPAN  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LOW_PCT   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_HIGH_PCT  = 2'd3;

  // Configuration reset values
  localparam logic [9:0]  INTERVAL_RST  = 10'd50;
  localparam logic [15:0] MIN_SPAN_RST  = 16'd64;
  localparam logic [6:0]  LOW_PCT_RST   = 7'd40;
  localparam logic [6:0]  HIGH_PCT_RST  = 7'd60;

  // Arithmetic constants
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [9:0]  DUTY_SCALE  = 10'd1000;
  localparam logic [9:0]  DUTY_MAX    = 10'd1000;
  localparam logic [15:0] FREQ_MAX    = 16'hFFFF;
  localparam logic [19:0] ONE_MILLION = 20'd1000000;

  // x / 100 == (x[22:2] * PCT_RECIP) >> 26 for any x below 2^23
  localparam logic [21:0] PCT_RECIP   = 22'd2684355;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> src/pdfm_store.sv
// Sample store: one write port, one read port with registered read data.
`default_nettype none
module pdfm_store #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/pdfm_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pdfm_div #(
  parameter int DW = 32,
  parameter int VW = 22
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DW-1:0]     dividend,
  input  wire logic [VW-1:0]     divisor,
  output logic      [DW-1:0]     quotient,
  output pdfm_pkg::div_stat_t    stat
);
  import pdfm_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          act_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;

  logic [VW:0]   rem_sh;
  logic          q_bit;
  logic [VW-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    q_bit   = rem_sh >= {1'b0, dvs_r};
    rem_nxt = q_bit ? VW'(rem_sh - {1'b0, dvs_r}) : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (act_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (act_r) begin
      quo_r <= {quo_r[DW-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = act_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

>>> src/pwm_duty_frequency_meter_top.sv
// Top level of the PWM duty and frequency meter: capture, edge pass, averaging.
//
//  channel   ports                                   handshake
//  input     start, busy, in_sample, in_last         start & !busy takes one word
//  result    out_strobe, out_valid_res, out_duty, out_freq,
//            out_min_raw, out_max_raw                one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   valid & ready writes
//
// A sample is taken whenever start is high and busy low; busy stays low until the window closes.
// The window closes on in_last or on the sample that fills MAX_SAMPLES.
// After closing, the block reads each sample back from the store once for the edge
// pass, then runs four serial divisions of width DW (DW = 29 at the default depth).
// With no qualifying cycle the divisions are skipped; with a span below min_span, so is the pass.
// The result word shows in the first cycle with busy low.
// Reset clears control state and loads the register defaults; the store needs no clear.
`default_nettype none
module pwm_duty_frequency_meter_top #(
  parameter int MAX_SAMPLES = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [15:0]           in_sample,
  input  wire logic                         in_last,
  output logic                              out_strobe,
  output logic                              out_valid_res,
  output logic [9:0]                        out_duty,
  output logic [15:0]                       out_freq,
  output logic signed [15:0]                out_min_raw,
  output logic signed [15:0]                out_max_raw,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pdfm_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [15:0]                  cfg_data
);
  import pdfm_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int TW = AW + 10;
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int DW = (TW + 10 > 23) ? TW + 10 : 23;
  localparam int VW = TW;

  localparam logic [3:0] S_COLLECT = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_DLO     = 4'd2;
  localparam logic [3:0] S_DHI     = 4'd3;
  localparam logic [3:0] S_LVL0    = 4'd4;
  localparam logic [3:0] S_PASS    = 4'd5;
  localparam logic [3:0] S_AVG     = 4'd6;
  localparam logic [3:0] S_DPER    = 4'd7;
  localparam logic [3:0] S_DHIG    = 4'd8;
  localparam logic [3:0] S_DFRQ    = 4'd9;
  localparam logic [3:0] S_DDUT    = 4'd10;

  logic [3:0]   state_r;
  logic [3:0]   state_nxt;

  // configuration
  logic [9:0]   interval_r;
  logic [15:0]  min_span_r;
  logic [6:0]   low_pct_r;
  logic [6:0]   high_pct_r;

  // capture
  logic [AW-1:0]      cnt_r;
  logic [AW-1:0]      last_idx_r;
  logic signed [15:0] min_r;
  logic signed [15:0] max_r;

  // edge pass
  logic [22:0]        lo_prod_r;
  logic [22:0]        hi_prod_r;
  logic signed [16:0] low_thr_r;
  logic signed [16:0] high_thr_r;
  logic [AW-1:0]      idx_r;
  logic [TW-1:0]      t_r;
  logic               lvl_r;
  logic [TW-1:0]      rise_r;
  logic [TW-1:0]      fall_r;
  logic               rise_seen_r;
  logic               fall_seen_r;
  logic [TW-1:0]      per_tot_r;
  logic [TW-1:0]      hi_tot_r;
  logic [NW-1:0]      cyc_r;
  logic [TW-1:0]      avg_per_r;
  logic [TW-1:0]      avg_hi_r;
  logic [15:0]        freq_r;

  // results
  logic               out_strobe_r;
  logic               out_valid_r;
  logic [9:0]         out_duty_r;
  logic [15:0]        out_freq_r;
  logic signed [15:0] out_min_r;
  logic signed [15:0] out_max_r;

  logic               accept;
  logic               close;
  logic signed [16:0] span17;
  logic [15:0]        span;
  logic               span_ok;
  logic [6:0]         lo_pct;
  logic [6:0]         hi_pct;
  logic [22:0]        lo_prod;
  logic [22:0]        hi_prod;
  logic [22:0]        thr_src;
  logic [42:0]        thr_mul;
  logic [TW+9:0]      duty_prod;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        rd_data;

  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [VW-1:0]      div_divisor;
  logic [DW-1:0]      div_quo;
  div_stat_t          div_stat;

  logic signed [16:0] smp;
  logic               rising;
  logic               falling;
  logic [TW-1:0]      per;
  logic [TW-1:0]      hi_time;
  logic               qualify;
  logic               pass_end;
  logic signed [16:0] thr_q;
  logic [15:0]        freq_sat;
  logic [9:0]         duty_sat;
  logic               meas_zero;

  assign busy      = (state_r != S_COLLECT);
  assign accept    = start && !busy;
  assign close     = in_last || (cnt_r == AW'(MAX_SAMPLES - 1));
  assign cfg_ready = 1'b1;

  assign span17  = $signed({max_r[15], max_r}) - $signed({min_r[15], min_r});
  assign span    = span17[15:0];
  assign span_ok = !span17[16] && (span >= min_span_r);
  assign lo_pct  = (low_pct_r > PCT_FULL) ? PCT_FULL : low_pct_r;
  assign hi_pct  = (high_pct_r > PCT_FULL) ? PCT_FULL : high_pct_r;
  assign lo_prod = span * lo_pct;
  assign hi_prod = span * hi_pct;
  assign duty_prod = avg_hi_r * DUTY_SCALE;

  // threshold offset: product over 100 by reciprocal multiply
  assign thr_src  = (state_r == S_DHI) ? hi_prod_r : lo_prod_r;
  assign thr_mul  = thr_src[22:2] * PCT_RECIP;
  assign thr_q    = $signed({min_r[15], min_r}) + $signed({1'b0, thr_mul[41:26]});
  assign freq_sat = (div_quo > DW'(FREQ_MAX)) ? FREQ_MAX : div_quo[15:0];
  assign duty_sat = (div_quo > DW'(DUTY_MAX)) ? DUTY_MAX : div_quo[9:0];

  // edge detection on the word coming back from the store
  always_comb begin
    smp     = $signed({rd_data[15], rd_data});
    rising  = !lvl_r && (smp >= high_thr_r);
    falling = lvl_r && (smp <= low_thr_r);
    per     = t_r - rise_r;
    hi_time = fall_r - rise_r;
    qualify = rise_seen_r && fall_seen_r && (t_r > rise_r) &&
              (hi_time != '0) && (per > hi_time);
    pass_end = (idx_r == last_idx_r);
  end

  // store read and divider launch
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_DHI: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_LVL0: begin
        if (last_idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
        end
      end
      S_PASS: begin
        if (!pass_end) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      S_AVG: begin
        if (cyc_r != '0) begin
          div_start    = 1'b1;
          div_dividend = DW'(per_tot_r);
          div_divisor  = VW'(cyc_r);
        end
      end
      S_DPER: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = DW'(hi_tot_r);
          div_divisor  = VW'(cyc_r);
        end
      end
      S_DHIG: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = DW'(ONE_MILLION);
          div_divisor  = avg_per_r;
        end
      end
      S_DFRQ: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = DW'(duty_prod);
          div_divisor  = avg_per_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_COLLECT: if (accept && close) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = span_ok ? S_DLO : S_COLLECT;
      S_DLO:     state_nxt = S_DHI;
      S_DHI:     state_nxt = S_LVL0;
      S_LVL0:    state_nxt = (last_idx_r == '0) ? S_AVG : S_PASS;
      S_PASS:    if (pass_end) state_nxt = S_AVG;
      S_AVG:     state_nxt = (cyc_r != '0) ? S_DPER : S_COLLECT;
      S_DPER:    if (div_stat.done) state_nxt = S_DHIG;
      S_DHIG:    if (div_stat.done) state_nxt = S_DFRQ;
      S_DFRQ:    if (div_stat.done) state_nxt = S_DDUT;
      S_DDUT:    if (div_stat.done) state_nxt = S_COLLECT;
      default:   state_nxt = S_COLLECT;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_COLLECT;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      interval_r   <= INTERVAL_RST;
      min_span_r   <= MIN_SPAN_RST;
      low_pct_r    <= LOW_PCT_RST;
      high_pct_r   <= HIGH_PCT_RST;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= ((state_r == S_CHECK) && !span_ok) ||
                      ((state_r == S_AVG) && (cyc_r == '0)) ||
                      ((state_r == S_DDUT) && div_stat.done);
      if (accept) begin
        cnt_r <= close ? '0 : cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_data[9:0];
          CFG_MIN_SPAN: min_span_r <= cfg_data;
          CFG_LOW_PCT:  low_pct_r  <= cfg_data[6:0];
          CFG_HIGH_PCT: high_pct_r <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_COLLECT: begin
        if (accept) begin
          if (cnt_r == '0) begin
            min_r <= in_sample;
            max_r <= in_sample;
          end else begin
            if (in_sample < min_r) min_r <= in_sample;
            if (in_sample > max_r) max_r <= in_sample;
          end
          last_idx_r <= cnt_r;
        end
      end
      S_CHECK: begin
        out_min_r <= min_r;
        out_max_r <= max_r;
        lo_prod_r <= lo_prod;
        hi_prod_r <= hi_prod;
        if (!span_ok) begin
          out_valid_r <= 1'b0;
          out_duty_r  <= '0;
          out_freq_r  <= '0;
        end
      end
      S_DLO: begin
        low_thr_r <= thr_q;
      end
      S_DHI: begin
        high_thr_r <= thr_q;
      end
      S_LVL0: begin
        lvl_r       <= smp >= high_thr_r;
        rise_r      <= '0;
        fall_r      <= '0;
        rise_seen_r <= 1'b0;
        fall_seen_r <= 1'b0;
        per_tot_r   <= '0;
        hi_tot_r    <= '0;
        cyc_r       <= '0;
        idx_r       <= AW'(1);
        t_r         <= TW'(interval_r);
      end
      S_PASS: begin
        if (rising) begin
          if (qualify) begin
            per_tot_r <= per_tot_r + per;
            hi_tot_r  <= hi_tot_r + hi_time;
            cyc_r     <= cyc_r + 1'b1;
          end
          rise_r      <= t_r;
          rise_seen_r <= 1'b1;
          fall_seen_r <= 1'b0;
          lvl_r       <= 1'b1;
        end else if (falling) begin
          fall_r      <= t_r;
          fall_seen_r <= 1'b1;
          lvl_r       <= 1'b0;
        end
        idx_r <= idx_r + 1'b1;
        t_r   <= t_r + TW'(interval_r);
      end
      S_AVG: begin
        if (cyc_r == '0) begin
          out_valid_r <= 1'b0;
          out_duty_r  <= '0;
          out_freq_r  <= '0;
        end
      end
      S_DPER: begin
        if (div_stat.done) avg_per_r <= div_quo[TW-1:0];
      end
      S_DHIG: begin
        if (div_stat.done) avg_hi_r <= div_quo[TW-1:0];
      end
      S_DFRQ: begin
        if (div_stat.done) freq_r <= freq_sat;
      end
      S_DDUT: begin
        if (div_stat.done) begin
          out_valid_r <= 1'b1;
          out_duty_r  <= duty_sat;
          out_freq_r  <= freq_r;
        end
      end
      default: begin
      end
    endcase
  end

  pdfm_store #(
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (cnt_r),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pdfm_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_strobe    = out_strobe_r;
  assign out_valid_res = out_valid_r;
  assign out_duty      = out_duty_r;
  assign out_freq      = out_freq_r;
  assign out_min_raw   = out_min_r;
  assign out_max_raw   = out_max_r;
  assign meas_zero     = (out_duty_r == '0) && (out_freq_r == '0);

  `PDFM_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "strobe held two cycles")
  `PDFM_ASSERT(a_strobe_idle, !out_strobe || !busy, "result word while busy")
  `PDFM_ASSERT(a_inv_zero, !out_strobe || out_valid_res || meas_zero, "invalid word nonzero")
  `PDFM_ASSERT(a_duty_range, !out_strobe || (out_duty <= DUTY_MAX), "duty above full scale")
  `PDFM_ASSERT_NEXT(a_close_busy, accept && in_last, busy, "window close did not start analysis")

endmodule
`default_nettype wire

>>> tb/tb_pwm_duty_frequency_meter_top.sv
// Testbench for the PWM duty and frequency meter: sample windows checked against a predictor.
`timescale 1ns / 1ps

localparam int STORE_DEPTH = 512;

typedef struct packed {
  logic               valid_res;
  logic [9:0]         duty;
  logic [15:0]        freq;
  logic signed [15:0] min_raw;
  logic signed [15:0] max_raw;
} meter_result_t;

class window_scoreboard;
  logic signed [15:0] store [STORE_DEPTH];
  int unsigned        fill;
  logic signed [15:0] run_min;
  logic signed [15:0] run_max;
  logic [9:0]         smp_interval;
  logic [15:0]        min_span;
  logic [6:0]         low_pct;
  logic [6:0]         high_pct;
  meter_result_t      expected_meas [$];
  int                 mismatches;

  function new();
    fill         = 0;
    run_min      = '0;
    run_max      = '0;
    smp_interval = pdfm_pkg::INTERVAL_RST;
    min_span     = pdfm_pkg::MIN_SPAN_RST;
    low_pct      = pdfm_pkg::LOW_PCT_RST;
    high_pct     = pdfm_pkg::HIGH_PCT_RST;
    mismatches   = 0;
  endfunction

  function void write_reg(logic [pdfm_pkg::CFG_IW-1:0] idx, logic [15:0] data);
    case (idx)
      pdfm_pkg::CFG_INTERVAL: smp_interval = data[9:0];
      pdfm_pkg::CFG_MIN_SPAN: min_span     = data;
      pdfm_pkg::CFG_LOW_PCT:  low_pct      = data[6:0];
      pdfm_pkg::CFG_HIGH_PCT: high_pct     = data[6:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_meas.size();
  endfunction

  // Edge pass over the held window, then the averages.
  function meter_result_t measure_window();
    meter_result_t r;
    int span, ms, lp, hp, lo_thr, hi_thr, s;
    int unsigned t, rise_t, fall_t, per, hi_t, per_sum, hi_sum, cycles;
    int unsigned avg_per, avg_hi, freq, duty;
    bit level, rise_ok, fall_ok;
    r = '0;
    r.min_raw = run_min;
    r.max_raw = run_max;
    span = run_max - run_min;
    ms = min_span;
    if (span < ms) return r;
    lp = (low_pct > 100) ? 100 : low_pct;
    hp = (high_pct > 100) ? 100 : high_pct;
    lo_thr = run_min + (span * lp) / 100;
    hi_thr = run_min + (span * hp) / 100;
    s = store[0];
    level = (s >= hi_thr);
    rise_t = 0;
    fall_t = 0;
    rise_ok = 0;
    fall_ok = 0;
    per_sum = 0;
    hi_sum = 0;
    cycles = 0;
    for (int i = 1; i < fill; i++) begin
      s = store[i];
      t = i * smp_interval;
      if (!level && s >= hi_thr) begin
        if (rise_ok && fall_ok && t > rise_t) begin
          per = t - rise_t;
          hi_t = fall_t - rise_t;
          if (hi_t > 0 && per > hi_t) begin
            per_sum += per;
            hi_sum += hi_t;
            cycles++;
          end
        end
        rise_t = t;
        rise_ok = 1;
        fall_ok = 0;
        level = 1;
      end else if (level && s <= lo_thr) begin
        fall_t = t;
        fall_ok = 1;
        level = 0;
      end
    end
    if (cycles == 0) return r;
    avg_per = per_sum / cycles;
    avg_hi = hi_sum / cycles;
    if (avg_per < 1) avg_per = 1;
    freq = 1000000 / avg_per;
    duty = (avg_hi * 1000) / avg_per;
    if (freq > 65535) freq = 65535;
    if (duty > 1000) duty = 1000;
    r.valid_res = 1'b1;
    r.duty = duty[9:0];
    r.freq = freq[15:0];
    return r;
  endfunction

  function void note_sample(logic signed [15:0] s, logic last);
    if (fill >= STORE_DEPTH) fill = 0;
    if (fill == 0) begin
      run_min = s;
      run_max = s;
    end else begin
      if (s < run_min) run_min = s;
      if (s > run_max) run_max = s;
    end
    store[fill] = s;
    fill++;
    if (!last && fill < STORE_DEPTH) return;
    expected_meas.push_back(measure_window());
    fill = 0;
  endfunction

  function void check_result(meter_result_t got);
    meter_result_t exp_r;
    if (expected_meas.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: valid=%0d duty=%0d freq=%0d min=%0d max=%0d",
                 got.valid_res, got.duty, got.freq, got.min_raw, got.max_raw);
      return;
    end
    exp_r = expected_meas.pop_front();
    if (got.valid_res !== exp_r.valid_res || got.duty !== exp_r.duty ||
        got.freq !== exp_r.freq || got.min_raw !== exp_r.min_raw ||
        got.max_raw !== exp_r.max_raw) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp valid=%0d duty=%0d freq=%0d min=%0d max=%0d",
                 exp_r.valid_res, exp_r.duty, exp_r.freq, exp_r.min_raw, exp_r.max_raw);
        $display("          got valid=%0d duty=%0d freq=%0d min=%0d max=%0d",
                 got.valid_res, got.duty, got.freq, got.min_raw, got.max_raw);
      end
    end
  endfunction
endclass

module tb_pwm_duty_frequency_meter_top;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 95;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic signed [15:0]               in_sample = '0;
  logic                             in_last = 1'b0;
  logic                             out_strobe;
  logic                             out_valid_res;
  logic [9:0]                       out_duty;
  logic [15:0]                      out_freq;
  logic signed [15:0]               out_min_raw;
  logic signed [15:0]               out_max_raw;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [pdfm_pkg::CFG_IW-1:0]      cfg_index = '0;
  logic [15:0]                      cfg_data = '0;

  window_scoreboard board;
  meter_result_t    got_word;
  bit               no_idle = 0;
  int               cycle_count = 0;
  int               sent;

  pwm_duty_frequency_meter_top #(.MAX_SAMPLES(STORE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_last(in_last),
    .out_strobe(out_strobe), .out_valid_res(out_valid_res),
    .out_duty(out_duty), .out_freq(out_freq),
    .out_min_raw(out_min_raw), .out_max_raw(out_max_raw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      got_word.valid_res = out_valid_res;
      got_word.duty      = out_duty;
      got_word.freq      = out_freq;
      got_word.min_raw   = out_min_raw;
      got_word.max_raw   = out_max_raw;
      board.check_result(got_word);
    end
  end

  // Hold start high across words; drop it only for a gap.
  task automatic send_word(input logic signed [15:0] s, input logic l);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_sample <= s;
    in_last <= l;
    do @(posedge clk); while (busy);
    board.note_sample(s, l);
    sent++;
  endtask

  task automatic program_registers(input int iv, input int ms, input int lp, input int hp);
    logic [15:0] vals [4];
    vals[pdfm_pkg::CFG_INTERVAL] = {6'($urandom()), 10'(iv)};
    vals[pdfm_pkg::CFG_MIN_SPAN] = 16'(ms);
    vals[pdfm_pkg::CFG_LOW_PCT]  = {9'($urandom()), 7'(lp)};
    vals[pdfm_pkg::CFG_HIGH_PCT] = {9'($urandom()), 7'(hp)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= pdfm_pkg::CFG_IW'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(pdfm_pkg::CFG_IW'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop start, wait for every pending result, then let the block settle.
  task automatic drain_results();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Square wave with random levels, period, duty and noise; close with last unless full.
  task automatic send_pwm_window(input int len, input bit close_with_last);
    int lo_v, hi_v, per, hi_len, ofs, noise, v;
    if ($urandom_range(0, 9) == 0) begin
      lo_v = -32768;
      hi_v = 32767;
    end else begin
      lo_v = $urandom_range(0, 65535) - 32768;
      hi_v = lo_v + $urandom_range(0, 32767 - lo_v);
    end
    per = $urandom_range(2, 16);
    hi_len = $urandom_range(0, per);
    ofs = $urandom_range(0, per - 1);
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
    for (int i = 0; i < len; i++) begin
      v = (((i + ofs) % per) < hi_len) ? hi_v : lo_v;
      if (noise != 0) v = v + $urandom_range(0, 2 * noise) - noise;
      send_word(clamp16(v), close_with_last && (i == len - 1));
    end
  endtask

  task automatic send_noise_burst(input int len);
    for (int i = 0; i < len; i++)
      send_word(16'($urandom()), (i == len - 1) || ($urandom_range(0, 5) == 0));
  endtask

  task automatic send_flat_window(input int len);
    int base, spread;
    base = $urandom_range(0, 65535) - 32768;
    spread = $urandom_range(0, 80);
    for (int i = 0; i < len; i++)
      send_word(clamp16(base + $urandom_range(0, spread)), i == len - 1);
  endtask

  task automatic run_phase(input int budget, input bit with_full);
    int kind, len, stop_at;
    stop_at = sent + budget;
    if (with_full) send_pwm_window(STORE_DEPTH, 1'b0);
    while (sent < stop_at) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      if (kind < 70) send_pwm_window(len, 1'b1);
      else if (kind < 85) send_noise_burst($urandom_range(1, 12));
      else send_flat_window(len);
    end
  endtask

  initial begin
    int iv, ms, lp, hp;
    board = new();
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the sample range, alternating, at reset settings.
    for (int i = 0; i < 7; i++)
      send_word((i % 2) ? 16'sh7FFF : 16'sh8000, i == 6);
    // Single-sample window.
    send_word(16'sd1234, 1'b1);
    // Span below the minimum.
    send_word(16'sd100, 1'b0);
    send_word(16'sd130, 1'b0);
    send_word(16'sd120, 1'b1);
    // Regular square wave.
    for (int i = 0; i < 12; i++)
      send_word(((i % 5) >= 2 && (i % 5) <= 4) ? 16'sd1000 : 16'sd0, i == 11);
    drain_results();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin iv = 1;    ms = 0;     lp = 0;   hp = 100; end
        1: begin iv = 1000; ms = 65535; lp = 100; hp = 0;   end
        2: begin iv = 0;    ms = 64;    lp = 40;  hp = 60;  end
        3: begin iv = 1023; ms = 1;     lp = 127; hp = 127; end
        4: begin iv = 20;   ms = 200;   lp = 60;  hp = 40;  end
        default: begin
          iv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 1023
                                           : $urandom_range(1, 1000);
          ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 500);
          lp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(10, 90);
          hp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(10, 90);
        end
      endcase
      program_registers(iv, ms, lp, hp);
      no_idle = (p == 2);
      run_phase(PHASE_ITEMS, p == 3);
      drain_results();
    end

    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
